>>> src/cbt_pkg.sv
// Shared types and constants for the byte tokenizer.
// Holds result kinds and the result record passed from front to back.
// No dependencies.
`default_nettype none
package cbt_pkg;
  localparam int PosBits = 24;
  localparam int KwChars = 7;
  localparam int QDepth = 4;
  localparam int QAw = 2;

  localparam logic [2:0] K_NUM = 3'd0;
  localparam logic [2:0] K_IDENT = 3'd1;
  localparam logic [2:0] K_OP1 = 3'd2;
  localparam logic [2:0] K_OP2 = 3'd3;
  localparam logic [2:0] K_PUNCT = 3'd4;
  localparam logic [2:0] K_SBYTE = 3'd5;
  localparam logic [2:0] K_SEND = 3'd6;
  localparam logic [2:0] K_END = 3'd7;

  typedef struct packed {
    logic [2:0]         kind;
    logic [31:0]        value;
    logic [7:0]         first_char;
    logic [7:0]         second_char;
    logic [7:0]         length;
    logic [3:0]         keyword;
    logic [PosBits-1:0] start_res;
    logic [15:0]        token_index;
    logic               last;
  } result_t;
endpackage
`default_nettype wire

>>> src/cbt_front.sv
// Front part: accepts bytes, keeps the lexer state, forms up to two requests per byte.
// Depends on cbt_pkg.
`default_nettype none
module cbt_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [7:0]       source_byte,
  output cbt_pkg::result_t      res0,
  output cbt_pkg::result_t      res1,
  output logic [1:0]            res_n
);
  import cbt_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_NUM, M_IDENT, M_OP, M_SKIP, M_CHR, M_CHRESC, M_CHRCLOSE, M_STR, M_STRESC
  } mode_t;

  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  mode_t             mode, mode_next;
  logic [31:0]       accum, accum_next;
  logic [7:0]        ident_length, ident_length_next;
  logic [7:0]        kwc [KwChars];
  logic [7:0]        pending_char, pending_char_next;
  logic [PosBits-1:0] token_start, token_start_next, position;
  logic [15:0]       token_counter, token_counter_next;

  logic [7:0] b;
  logic is_dig, is_alp, is_op, is_op2, is_pun;
  logic [3:0] kw_code;
  logic kw_wr0, kw_wrn;
  logic [31:0] acc_mul;

  assign b = source_byte;
  assign is_dig = (b >= 8'h30) && (b <= 8'h39);
  assign is_alp = (b == 8'h5f) || ((b >= 8'h41) && (b <= 8'h5a)) ||
                  ((b >= 8'h61) && (b <= 8'h7a));
  assign is_op = (b == "*") || (b == "/") || (b == "+") || (b == "-") || (b == "<") ||
                 (b == "=") || (b == ">") || (b == "|") || (b == "&") || (b == "!");
  assign is_op2 = (b == "=") || (b == "&") || (b == "|");
  assign is_pun = (b == "(") || (b == ")") || (b == "{") || (b == "}") ||
                  (b == ",") || (b == ";");
  assign acc_mul = (accum << 3) + (accum << 1) + {24'd0, b - 8'h30};

  // keyword match over stored leading characters
  function automatic logic eq(input logic [7:0] s [KwChars], input logic [55:0] w,
                              input int n);
    logic r;
    r = 1'b1;
    for (int i = 0; i < KwChars; i++)
      if (i < n && s[i] != w[55-8*i -: 8]) r = 1'b0;
    return r;
  endfunction

  always_comb begin
    kw_code = 4'd0;
    unique case (ident_length)
      8'd2: if (eq(kwc, {"if", 40'd0}, 2)) kw_code = 4'd3;
      8'd3: if (eq(kwc, {"int", 32'd0}, 3)) kw_code = 4'd1;
      8'd4: begin
        if (eq(kwc, {"char", 24'd0}, 4)) kw_code = 4'd2;
        else if (eq(kwc, {"else", 24'd0}, 4)) kw_code = 4'd4;
        else if (eq(kwc, {"FILE", 24'd0}, 4)) kw_code = 4'd2;
        else if (eq(kwc, {"exit", 24'd0}, 4)) kw_code = 4'd13;
      end
      8'd5: begin
        if (eq(kwc, {"fopen", 16'd0}, 5)) kw_code = 4'd11;
        else if (eq(kwc, {"fread", 16'd0}, 5)) kw_code = 4'd12;
      end
      8'd6: begin
        if (eq(kwc, {"return", 8'd0}, 6)) kw_code = 4'd5;
        else if (eq(kwc, {"printf", 8'd0}, 6)) kw_code = 4'd6;
        else if (eq(kwc, {"memcmp", 8'd0}, 6)) kw_code = 4'd7;
        else if (eq(kwc, {"malloc", 8'd0}, 6)) kw_code = 4'd8;
        else if (eq(kwc, {"memchr", 8'd0}, 6)) kw_code = 4'd9;
      end
      8'd7: if (eq(kwc, "memmove", 7)) kw_code = 4'd10;
      default: kw_code = 4'd0;
    endcase
  end

  // next-state and request formation
  always_comb begin
    result_t r;
    logic fresh, flush;
    logic [15:0] tc;
    mode_next = mode; accum_next = accum; ident_length_next = ident_length;
    pending_char_next = pending_char; token_start_next = token_start;
    token_counter_next = token_counter;
    kw_wr0 = 1'b0; kw_wrn = 1'b0;
    res0 = '0; res1 = '0; res_n = 2'd0;
    fresh = 1'b0; flush = 1'b0;
    tc = token_counter;
    r = '0;
    r.start_res = token_start;
    r.token_index = tc;
    if (b == 8'd0) begin
      flush = 1'b1;
    end else begin
      unique case (mode)
        M_IDLE: fresh = 1'b1;
        M_NUM: if (is_dig) accum_next = acc_mul;
               else begin flush = 1'b1; fresh = 1'b1; end
        M_IDENT: if (is_alp || is_dig) begin
                   kw_wrn = ident_length < 8'(KwChars);
                   if (ident_length != 8'hff) ident_length_next = ident_length + 8'd1;
                 end else begin flush = 1'b1; fresh = 1'b1; end
        M_OP: if (pending_char == "/" && b == "/") mode_next = M_SKIP;
              else if (is_op2) begin
                r.kind = K_OP2; r.first_char = pending_char; r.second_char = b;
                res0 = r; res_n = 2'd1;
                if (tc != 16'hffff) tc = tc + 16'd1;
                mode_next = M_IDLE;
              end else begin flush = 1'b1; fresh = 1'b1; end
        M_SKIP: if (b == 8'h0a) mode_next = M_IDLE;
        M_CHR: if (b == 8'h5c) mode_next = M_CHRESC;
               else begin accum_next = {24'd0, b}; mode_next = M_CHRCLOSE; end
        M_CHRESC: begin
          accum_next = (b == "n") ? 32'd10 : (b == 8'h5c) ? 32'd92 :
                       (b == 8'h27) ? 32'd39 : 32'd0;
          mode_next = M_CHRCLOSE;
        end
        M_CHRCLOSE: begin
          r.kind = K_NUM; r.value = accum; res0 = r; res_n = 2'd1;
          if (tc != 16'hffff) tc = tc + 16'd1;
          mode_next = M_IDLE;
        end
        M_STR: if (b == 8'h5c) mode_next = M_STRESC;
               else if (b == 8'h22) begin
                 r.kind = K_SEND; res0 = r; res_n = 2'd1;
                 if (tc != 16'hffff) tc = tc + 16'd1;
                 mode_next = M_IDLE;
               end else begin
                 r.kind = K_SBYTE; r.value = {24'd0, b}; res0 = r; res_n = 2'd1;
               end
        M_STRESC: begin
          r.kind = K_SBYTE; r.value = (b == "n") ? 32'd10 : {24'd0, b};
          res0 = r; res_n = 2'd1; mode_next = M_STR;
        end
        default: fresh = 1'b1;
      endcase
    end
    // pending token emitted ahead of whatever this byte starts
    if (flush && (mode == M_NUM || mode == M_IDENT || mode == M_OP)) begin
      r = '0; r.start_res = token_start; r.token_index = tc;
      if (mode == M_NUM) begin r.kind = K_NUM; r.value = accum; end
      else if (mode == M_IDENT) begin
        r.kind = K_IDENT; r.length = ident_length; r.keyword = kw_code;
      end else begin r.kind = K_OP1; r.first_char = pending_char; end
      res0 = r; res_n = 2'd1;
      if (tc != 16'hffff) tc = tc + 16'd1;
      mode_next = M_IDLE;
    end
    if (b == 8'd0) begin
      r = '0; r.kind = K_END; r.start_res = position; r.token_index = tc;
      if (res_n == 2'd0) begin res0 = r; res_n = 2'd1; end
      else begin res1 = r; res_n = 2'd2; end
    end else if (fresh) begin
      token_start_next = position;
      mode_next = M_IDLE;
      if (is_dig) begin mode_next = M_NUM; accum_next = {24'd0, b - 8'h30}; end
      else if (b == "#") mode_next = M_SKIP;
      else if (b == 8'h27) begin mode_next = M_CHR; accum_next = 32'd0; end
      else if (b == 8'h22) mode_next = M_STR;
      else if (is_alp) begin
        mode_next = M_IDENT; kw_wr0 = 1'b1; ident_length_next = 8'd1;
      end else if (is_op) begin mode_next = M_OP; pending_char_next = b; end
      else if (is_pun) begin
        r = '0; r.kind = K_PUNCT; r.first_char = b; r.start_res = position;
        r.token_index = tc;
        if (res_n == 2'd0) begin res0 = r; res_n = 2'd1; end
        else begin res1 = r; res_n = 2'd2; end
        if (tc != 16'hffff) tc = tc + 16'd1;
      end
    end
    if (res_n == 2'd1) res0.last = 1'b1;
    if (res_n == 2'd2) res1.last = 1'b1;
    token_counter_next = tc;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; accum <= '0; ident_length <= '0; pending_char <= '0;
      token_start <= '0; position <= '0; token_counter <= '0;
    end else if (in_valid) begin
      if (b == 8'd0) begin
        mode <= M_IDLE; accum <= '0; ident_length <= '0; pending_char <= '0;
        token_start <= '0; position <= '0; token_counter <= '0;
      end else begin
        mode <= mode_next; accum <= accum_next; ident_length <= ident_length_next;
        pending_char <= pending_char_next; token_start <= token_start_next;
        token_counter <= token_counter_next;
        if (position != PosMax) position <= position + PosBits'(1);
      end
    end
  end

  // keyword character store, undefined until written
  always_ff @(posedge clk) begin
    if (in_valid && kw_wr0) kwc[0] <= b;
    if (in_valid && kw_wrn) kwc[ident_length[2:0]] <= b;
  end
endmodule
`default_nettype wire

>>> src/cbt_queue.sv
// Back part: result queue taking up to two requests a cycle, draining one while the receiver is ready.
// Depends on cbt_pkg.
`default_nettype none
module cbt_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  cbt_pkg::result_t      d0,
  input  cbt_pkg::result_t      d1,
  input  wire logic [1:0]       n,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cbt_pkg::result_t      q
);
  import cbt_pkg::*;

  result_t        mem [QDepth];
  logic [QAw-1:0] wp, rp;
  logic [QAw:0]   cnt;
  logic           pop;
  logic [QAw:0]   add;

  assign out_valid = cnt != '0;
  assign q = mem[rp];
  assign pop = out_valid && out_ready;
  assign room = cnt <= (QAw+1)'(QDepth - 2);
  assign add = push ? {1'b0, n} : '0;

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      wp <= wp + add[QAw-1:0];
      if (pop) rp <= rp + QAw'(1);
      cnt <= cnt + add - {{QAw{1'b0}}, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && n != 2'd0) mem[wp] <= d0;
    if (push && n == 2'd2) mem[wp + QAw'(1)] <= d1;
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= (QAw+1)'(QDepth))
    else $error("queue overflow");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> cnt == $past(cnt) - (QAw+1)'(1)) else $error("count slip");
  a_room: assert property (@(posedge clk) disable iff (rst) push |-> room)
    else $error("push without room");
endmodule
`default_nettype wire

>>> src/c_subset_byte_tokenizer_unit.sv
// Top level of the byte tokenizer: front lexer plus result queue.
// Depends on cbt_pkg, cbt_front, cbt_queue.
//
// Input channel: source_byte with in_valid/in_ready, one byte per request.
// A zero byte ends the source; state returns to reset for the next source.
// Output channel: one token record per request with out_valid/out_ready.
// Each byte yields zero, one or two results; last marks the final one.
// A result is queued when its byte is accepted and offered once the results ahead of it have drained.
// Throughput: one byte per cycle while the queue has room, set by the lexer
// state update; a byte giving two results leaves two queue entries to drain.
// The four-entry queue takes a byte while it has room for two results,
// so a stalled receiver stops input only once three entries are unread.
// Reset (rst, synchronous) empties the queue and sets the lexer idle.
`default_nettype none
module c_subset_byte_tokenizer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  source_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic signed [31:0] value,
  output logic [7:0]       first_char,
  output logic [7:0]       second_char,
  output logic [7:0]       length,
  output logic [3:0]       keyword,
  output logic [cbt_pkg::PosBits-1:0] start_res,
  output logic [15:0]      token_index,
  output logic             last
);
  import cbt_pkg::*;

  result_t r0, r1, q;
  logic [1:0] n;
  logic room, acc;

  assign in_ready = room;
  assign acc = in_valid && room;

  cbt_front u_front (.clk, .rst, .in_valid(acc), .source_byte, .res0(r0), .res1(r1),
                     .res_n(n));
  cbt_queue u_queue (.clk, .rst, .push(acc), .d0(r0), .d1(r1), .n, .room,
                     .out_valid, .out_ready, .q);

  assign kind = q.kind;
  assign value = q.value;
  assign first_char = q.first_char;
  assign second_char = q.second_char;
  assign length = q.length;
  assign keyword = q.keyword;
  assign start_res = q.start_res;
  assign token_index = q.token_index;
  assign last = q.last;

  a_end: assert property (@(posedge clk) disable iff (rst)
    (acc && source_byte == 8'd0) |=> out_valid) else $error("end result missing");
  a_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == K_END) |-> last) else $error("end not last");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (acc && source_byte == 8'd0) |-> n != 2'd0) else $error("no end request");
endmodule
`default_nettype wire
